[design/triage_three_queue_engine_assert.svh]
// assertion macros shared by the triage engine modules
// expects clk and rst_n in the scope of each use
`ifndef TRIAGE_THREE_QUEUE_ENGINE_ASSERT_SVH
`define TRIAGE_THREE_QUEUE_ENGINE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// property checked at every clock edge outside reset
`define TQE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition in one cycle implies a condition in the next
`define TQE_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define TQE_ASSERT(lbl, prop, msg)
`define TQE_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

[design/tqe_pkg.sv]
`timescale 1ns / 1ps
// shared types and codes for the triage three-queue engine
// no dependencies

package tqe_pkg;

  localparam int TAG_W = 32;

  // record as kept in the stores, tag in the low bits
  typedef struct packed {
    logic [1:0]       typ;
    logic [2:0]       sev;
    logic [7:0]       age;
    logic [TAG_W-1:0] tag;
  } rec_t;

  // request kinds
  localparam logic [1:0] KIND_ADMIT = 2'd0;
  localparam logic [1:0] KIND_SERVE = 2'd1;
  localparam logic [1:0] KIND_XFER  = 2'd2;
  localparam logic [1:0] KIND_NOP   = 2'd3;

  // sectors
  localparam logic [1:0] SEC_NONE  = 2'd0;
  localparam logic [1:0] SEC_STACK = 2'd1;
  localparam logic [1:0] SEC_FIFO  = 2'd2;
  localparam logic [1:0] SEC_RING  = 2'd3;

  // result status
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_SEV  = 3'd1;
  localparam logic [2:0] ST_BAD_TYPE = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_DROPPED  = 3'd5;
  localparam logic [2:0] ST_BAD_SEC  = 3'd6;

  localparam logic [2:0] SEV_MIN       = 3'd1;
  localparam logic [2:0] SEV_MAX       = 3'd5;
  localparam logic [2:0] THRESHOLD_RST = 3'd4;

  // register indexes
  localparam logic REG_THRESHOLD = 1'b0;

  // cell operations
  localparam logic [1:0] CELL_HOLD = 2'd0;
  localparam logic [1:0] CELL_PREV = 2'd1;
  localparam logic [1:0] CELL_NEXT = 2'd2;
  localparam logic [1:0] CELL_LOAD = 2'd3;

  // command into one store chain
  typedef struct packed {
    logic push;
    logic pop;
    rec_t rec;
  } chain_cmd_t;

  // status out of one store chain
  typedef struct packed {
    logic empty;
    logic full;
    rec_t head;
  } chain_stat_t;

endpackage

[design/tqe_cell.sv]
`timescale 1ns / 1ps
// one record slot of a store chain
// uses tqe_pkg for the record type and cell operation codes

module tqe_cell
  import tqe_pkg::*;
(
  input  logic       clk,
  input  logic [1:0] op,
  input  rec_t       prev_d,
  input  rec_t       next_d,
  input  rec_t       load_d,
  output rec_t       q
);

  rec_t q_r;
  rec_t q_nxt;

  always_comb begin
    case (op)
      CELL_HOLD: q_nxt = q_r;
      CELL_PREV: q_nxt = prev_d;
      CELL_NEXT: q_nxt = next_d;
      CELL_LOAD: q_nxt = load_d;
      default:   q_nxt = q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

[design/tqe_chain.sv]
`timescale 1ns / 1ps
// one record store built as a row of tqe_cell slots, head or top in slot 0
// uses tqe_pkg, tqe_cell and the assertion macro header
`include "triage_three_queue_engine_assert.svh"

module tqe_chain
  import tqe_pkg::*;
#(
  parameter int DEPTH     = 16,
  parameter bit LIFO      = 1'b0,
  parameter bit OVERWRITE = 1'b0,
  parameter int LW        = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  chain_cmd_t    cmd,
  output chain_stat_t   stat,
  output logic [LW-1:0] level_nxt
);

  logic [LW-1:0] level_r;
  logic          full;
  logic          eff_pop;
  logic [LW-1:0] wpos;
  logic [1:0]    cell_op [DEPTH];
  rec_t          cell_q  [DEPTH];

  assign full    = (level_r >= LW'(DEPTH));
  // a full overwriting store drops its oldest entry on push
  assign eff_pop = cmd.pop | (OVERWRITE & cmd.push & full);
  assign wpos    = eff_pop ? level_r - LW'(1) : level_r;

  always_comb begin
    level_nxt = level_r;
    if (cmd.push && !eff_pop) begin
      level_nxt = level_r + LW'(1);
    end else if (!cmd.push && eff_pop) begin
      level_nxt = level_r - LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
    end else begin
      level_r <= level_nxt;
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_op[i] = CELL_HOLD;
      if (LIFO) begin
        if (cmd.push) begin
          if (i == 0) cell_op[i] = CELL_LOAD;
          else if (!cmd.pop) cell_op[i] = CELL_PREV;
        end else if (cmd.pop) begin
          cell_op[i] = CELL_NEXT;
        end
      end else begin
        if (cmd.push && (LW'(i) == wpos)) cell_op[i] = CELL_LOAD;
        else if (eff_pop) cell_op[i] = CELL_NEXT;
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    rec_t prev_d;
    rec_t next_d;
    if (g == 0) begin : g_first
      assign prev_d = cell_q[g];
    end else begin : g_mid_prev
      assign prev_d = cell_q[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign next_d = cell_q[g];
    end else begin : g_mid_next
      assign next_d = cell_q[g+1];
    end
    tqe_cell u_cell (
      .clk    (clk),
      .op     (cell_op[g]),
      .prev_d (prev_d),
      .next_d (next_d),
      .load_d (cmd.rec),
      .q      (cell_q[g])
    );
  end

  assign stat.empty = (level_r == '0);
  assign stat.full  = full;
  assign stat.head  = cell_q[0];

  `TQE_ASSERT(a_level_bound, level_r <= LW'(DEPTH), "store level beyond depth")
  `TQE_ASSERT(a_no_pop_empty, !(cmd.pop && level_r == '0), "pop from empty store")
  `TQE_ASSERT(a_no_push_full, !(cmd.push && full && !cmd.pop && !OVERWRITE),
              "push into full store")
  `TQE_ASSERT_NEXT(a_push_grows, cmd.push && !eff_pop && rst_n,
                   level_r == $past(level_r) + LW'(1), "level did not grow on push")

endmodule

[design/triage_three_queue_engine.sv]
`timescale 1ns / 1ps
// triage engine top: request decode, three store chains, result register, config port
// uses tqe_pkg, tqe_chain (tqe_cell) and the assertion macro header
//
//  channel | dir | handshake                 | payload
//  --------+-----+---------------------------+--------------------------------------
//  in_     | in  | in_tvalid / in_tready     | in_tuser kind, in_tdata record + sectors
//  out_    | out | out_tvalid / out_tready   | out_tuser status, out_tdata record + counts
//  cfg_    | in  | psel/penable/pwrite/pready| emergency_threshold at byte address 0
//
// each request is decoded against the store heads, and the cell rows shift or
// load at the same edge that captures the result
// one transfer per cycle while the result output is not stalled; the result is registered
// and appears in the cycle after its request is taken; a stalled result holds in the
// output register, and a new request is taken in the cycle the waiting result leaves
// synchronous active-low reset empties all stores and sets the threshold to 4
`include "triage_three_queue_engine_assert.svh"

module triage_three_queue_engine
  import tqe_pkg::*;
#(
  parameter int STACK_DEPTH = 16,
  parameter int FIFO_DEPTH  = 16,
  parameter int RING_DEPTH  = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // request stream
  input  logic        in_tvalid,
  output logic        in_tready,
  // [31:0] record_tag, [39:32] record_age, [42:40] record_severity,
  // [44:43] record_type, [46:45] source_sector, [48:47] dest_sector, rest zero
  input  logic [55:0] in_tdata,
  // [1:0] kind
  input  logic [1:0]  in_tuser,
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // [1:0] placed_sector, [33:2] out_tag, [41:34] out_age, [44:42] out_severity,
  // [46:45] out_type, [51:47] stack_count, [56:52] fifo_count,
  // [60:57] ring_count, rest zero
  output logic [63:0] out_tdata,
  // [2:0] status
  output logic [2:0]  out_tuser,
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int SLW = $clog2(STACK_DEPTH + 1);
  localparam int FLW = $clog2(FIFO_DEPTH + 1);
  localparam int RLW = $clog2(RING_DEPTH + 1);

  // configuration register
  logic [2:0] threshold_r;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready
                      & (cfg_paddr[2] == REG_THRESHOLD);
  assign cfg_prdata = (cfg_paddr[2] == REG_THRESHOLD) ? {29'd0, threshold_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RST;
    end else if (cfg_wr) begin
      threshold_r <= cfg_pwdata[2:0];
    end
  end

  // request fields
  logic [1:0] kind;
  rec_t       in_rec;
  logic [1:0] src;
  logic [1:0] dst;
  logic       in_acc;

  assign kind       = in_tuser;
  assign in_rec.tag = in_tdata[31:0];
  assign in_rec.age = in_tdata[39:32];
  assign in_rec.sev = in_tdata[42:40];
  assign in_rec.typ = in_tdata[44:43];
  assign src        = in_tdata[46:45];
  assign dst        = in_tdata[48:47];

  logic out_valid_r;
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  // store chains
  chain_cmd_t    stack_cmd, fifo_cmd, ring_cmd;
  chain_stat_t   stack_st, fifo_st, ring_st;
  logic [SLW-1:0] stack_lvl_nxt;
  logic [FLW-1:0] fifo_lvl_nxt;
  logic [RLW-1:0] ring_lvl_nxt;

  tqe_chain #(.DEPTH(STACK_DEPTH), .LIFO(1'b1), .OVERWRITE(1'b0)) u_stack (
    .clk (clk), .rst_n (rst_n), .cmd (stack_cmd), .stat (stack_st),
    .level_nxt (stack_lvl_nxt)
  );

  tqe_chain #(.DEPTH(FIFO_DEPTH), .LIFO(1'b0), .OVERWRITE(1'b0)) u_fifo (
    .clk (clk), .rst_n (rst_n), .cmd (fifo_cmd), .stat (fifo_st),
    .level_nxt (fifo_lvl_nxt)
  );

  tqe_chain #(.DEPTH(RING_DEPTH), .LIFO(1'b0), .OVERWRITE(1'b1)) u_ring (
    .clk (clk), .rst_n (rst_n), .cmd (ring_cmd), .stat (ring_st),
    .level_nxt (ring_lvl_nxt)
  );

  // decode against the current store heads
  logic [1:0] target;
  logic       sev_ok;
  logic       src_empty;
  logic       dst_full;
  logic       target_full;
  rec_t       src_head;
  logic [1:0] push_sec;
  logic [1:0] pop_sec;
  logic [2:0] status;
  logic [1:0] placed;
  rec_t       rec;

  assign sev_ok = (in_rec.sev >= SEV_MIN) && (in_rec.sev <= SEV_MAX);
  assign target = (in_rec.sev >= threshold_r) ? SEC_STACK :
                  (in_rec.typ == SEC_STACK)   ? SEC_NONE  : in_rec.typ;

  // the ring is never treated as full in these checks: it overwrites instead
  always_comb begin
    case (src)
      SEC_STACK: begin src_empty = stack_st.empty; src_head = stack_st.head; end
      SEC_FIFO:  begin src_empty = fifo_st.empty;  src_head = fifo_st.head;  end
      SEC_RING:  begin src_empty = ring_st.empty;  src_head = ring_st.head;  end
      default:   begin src_empty = 1'b1;           src_head = '0;            end
    endcase
    case (dst)
      SEC_STACK: dst_full = stack_st.full;
      SEC_FIFO:  dst_full = fifo_st.full;
      default:   dst_full = 1'b0;
    endcase
    case (target)
      SEC_STACK: target_full = stack_st.full;
      SEC_FIFO:  target_full = fifo_st.full;
      default:   target_full = 1'b0;
    endcase
  end

  always_comb begin
    push_sec = SEC_NONE;
    pop_sec  = SEC_NONE;
    status   = ST_BAD_SEC;
    placed   = SEC_NONE;
    rec      = '0;
    case (kind)
      KIND_ADMIT: begin
        rec = in_rec;
        if (!sev_ok) begin
          status = ST_BAD_SEV;
        end else if (in_rec.typ == SEC_NONE) begin
          status = ST_BAD_TYPE;
        end else if (target == SEC_NONE) begin
          status = ST_OK;
        end else if (target_full) begin
          status = ST_FULL;
        end else begin
          push_sec = target;
          placed   = target;
          status   = ST_OK;
        end
      end
      KIND_SERVE: begin
        if (src != SEC_NONE) begin
          if (src_empty) begin
            status = ST_EMPTY;
          end else begin
            pop_sec = src;
            rec     = src_head;
            placed  = src;
            status  = ST_OK;
          end
        end
      end
      KIND_XFER: begin
        if (src != SEC_NONE && dst != SEC_NONE) begin
          if (src_empty) begin
            status = ST_EMPTY;
          end else if (dst != src && dst_full) begin
            status = ST_FULL;
          end else begin
            pop_sec  = src;
            push_sec = dst;
            rec      = src_head;
            placed   = dst;
            status   = ST_OK;
          end
        end
      end
      default: begin
        status = ST_BAD_SEC;
      end
    endcase
    // push into a full ring that is not also popped drops its oldest record
    if (push_sec == SEC_RING && ring_st.full && pop_sec != SEC_RING) begin
      status = ST_DROPPED;
    end
  end

  always_comb begin
    stack_cmd.push = in_acc && (push_sec == SEC_STACK);
    stack_cmd.pop  = in_acc && (pop_sec == SEC_STACK);
    stack_cmd.rec  = rec;
    fifo_cmd.push  = in_acc && (push_sec == SEC_FIFO);
    fifo_cmd.pop   = in_acc && (pop_sec == SEC_FIFO);
    fifo_cmd.rec   = rec;
    ring_cmd.push  = in_acc && (push_sec == SEC_RING);
    ring_cmd.pop   = in_acc && (pop_sec == SEC_RING);
    ring_cmd.rec   = rec;
  end

  // levels after this request, fitted to the result field widths
  logic [31:0] stack_cnt_w, fifo_cnt_w, ring_cnt_w;
  assign stack_cnt_w = 32'(stack_lvl_nxt);
  assign fifo_cnt_w  = 32'(fifo_lvl_nxt);
  assign ring_cnt_w  = 32'(ring_lvl_nxt);

  // result register
  logic [2:0] status_r;
  logic [1:0] placed_r;
  rec_t       rec_r;
  logic [4:0] stack_cnt_r;
  logic [4:0] fifo_cnt_r;
  logic [3:0] ring_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      status_r    <= status;
      placed_r    <= placed;
      rec_r       <= rec;
      stack_cnt_r <= stack_cnt_w[4:0];
      fifo_cnt_r  <= fifo_cnt_w[4:0];
      ring_cnt_r  <= ring_cnt_w[3:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {3'd0, ring_cnt_r, fifo_cnt_r, stack_cnt_r,
                       rec_r.typ, rec_r.sev, rec_r.age, rec_r.tag, placed_r};

  `TQE_ASSERT_NEXT(a_acc_gives_result, in_acc, out_valid_r,
                   "accepted request left no result")
  `TQE_ASSERT_NEXT(a_bad_sev, in_acc && kind == KIND_ADMIT && !sev_ok,
                   status_r == ST_BAD_SEV && placed_r == SEC_NONE,
                   "bad severity not reported")
  `TQE_ASSERT_NEXT(a_nop_kind, in_acc && kind == KIND_NOP,
                   status_r == ST_BAD_SEC && placed_r == SEC_NONE && rec_r == '0,
                   "unused kind changed a result field")
  `TQE_ASSERT(a_one_push, !(stack_cmd.push && fifo_cmd.push) &&
              !(stack_cmd.push && ring_cmd.push) && !(fifo_cmd.push && ring_cmd.push),
              "request pushed into two stores")

endmodule
